// ----- sv/hashed_lru_key_cache_unit_defines.svh -----
// assertion macros for the checker file
`ifndef HASHED_LRU_KEY_CACHE_UNIT_DEFINES_SVH
`define HASHED_LRU_KEY_CACHE_UNIT_DEFINES_SVH

// general form: explicit clock and reset
`define HLKC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// shorthand on the block's own clock and reset names
`define HLKC_CHECK(label, prop, msg) \
   `HLKC_ASSERT(label, clock, reset, prop, msg)

`endif

// ----- sv/hlkc_pkg.sv -----
`timescale 1ns / 1ps

package hlkc_pkg;

   // default geometry
   localparam int BUCKETS_DEF  = 64;
   localparam int WAYS_DEF     = 8;
   localparam int KEY_BITS_DEF = 64;
   localparam int ID_BITS_DEF  = 32;

   // fixed field widths of the request and response
   localparam int BUCKET_W = 6;
   localparam int TAG_W    = 64;
   localparam int UID_W    = 32;
   localparam int TOTAL_W  = 10;

   // operation codes
   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [BUCKET_W-1:0]   bucket;
      logic [TAG_W-1:0]      key_tag;
      logic [UID_W-1:0]      uid_in;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [UID_W-1:0]      uid_out;
      logic                  status;
      logic                  evicted;
      logic [TOTAL_W-1:0]    total_entries;
   } rsp_type;

   // outcome of one bucket update
   typedef struct packed {
      logic hit;
      logic miss;
      logic evicted;
      logic grow;
      logic shrink;
      logic meta_we;
      logic data_we;
   } upd_flags_type;

endpackage

// ----- sv/hlkc_ram.sv -----
`timescale 1ns / 1ps

module hlkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/hlkc_bucket_logic.sv -----
`timescale 1ns / 1ps

module hlkc_bucket_logic import hlkc_pkg::*; #(
   parameter int WAYS     = WAYS_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int ID_BITS  = ID_BITS_DEF,
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1,
   localparam int FILL_W  = $clog2(WAYS + 1)
) (
   input  func_type                          func,
   input  logic [KEY_BITS-1:0]               key,
   input  logic [ID_BITS-1:0]                uid,
   input  logic [FILL_W-1:0]                 fill,
   input  logic [WAYS-1:0][WAY_W-1:0]        order,
   input  logic [WAYS-1:0][KEY_BITS-1:0]     keys,
   input  logic [WAYS-1:0][ID_BITS-1:0]      ids,
   output logic [FILL_W-1:0]                 fill_new,
   output logic [WAYS-1:0][WAY_W-1:0]        order_new,
   output logic [WAYS-1:0][KEY_BITS-1:0]     keys_new,
   output logic [WAYS-1:0][ID_BITS-1:0]      ids_new,
   output logic [ID_BITS-1:0]                hit_id,
   output upd_flags_type                     flags
);

   logic [WAYS-1:0]              valid;
   logic [WAYS-1:0]              match;
   logic                         found;
   logic                         full;
   logic [WAY_W-1:0]             match_way;
   logic [WAY_W-1:0]             hit_pos;
   logic [WAY_W-1:0]             ins_pos;
   logic [WAY_W-1:0]             mv_pos;
   logic [WAY_W-1:0]             ins_slot;
   logic [WAYS-1:0][WAY_W-1:0]   front_order;
   logic [WAYS-1:0][WAY_W-1:0]   drop_order;

   // which ways hold live entries, and which one matches the key
   always_comb begin
      valid = '0;
      for (int p = 0; p < WAYS; p++) begin
         if (FILL_W'(p) < fill) begin
            valid[order[p]] = 1'b1;
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         match[w] = valid[w] && (keys[w] == key);
      end
   end

   assign found = |match;
   assign full  = (fill == FILL_W'(WAYS));

   // way of the match and its position in the recency list
   always_comb begin
      match_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (match[w]) begin
            match_way = WAY_W'(w);
         end
      end
      hit_pos = '0;
      for (int p = 0; p < WAYS; p++) begin
         if ((order[p] == match_way) && (FILL_W'(p) < fill)) begin
            hit_pos = WAY_W'(p);
         end
      end
   end

   // new entry goes to the first free position, or replaces the lru one
   assign ins_pos  = full ? WAY_W'(WAYS - 1) : WAY_W'(fill);
   assign mv_pos   = found ? hit_pos : ins_pos;
   assign ins_slot = order[ins_pos];

   // move the chosen position to the front
   always_comb begin
      front_order[0] = order[mv_pos];
      for (int p = 1; p < WAYS; p++) begin
         front_order[p] = (WAY_W'(p) <= mv_pos) ? order[p-1] : order[p];
      end
   end

   // close the gap of a removed entry and park its slot after the live ones
   always_comb begin
      for (int p = 0; p < WAYS; p++) begin
         if (WAY_W'(p) < hit_pos) begin
            drop_order[p] = order[p];
         end else if (FILL_W'(p + 1) < fill) begin
            drop_order[p] = order[(p + 1 < WAYS) ? p + 1 : p];
         end else if (FILL_W'(p + 1) == fill) begin
            drop_order[p] = order[hit_pos];
         end else begin
            drop_order[p] = order[p];
         end
      end
   end

   // per-operation update
   always_comb begin
      fill_new  = fill;
      order_new = order;
      keys_new  = keys;
      ids_new   = ids;
      hit_id    = '0;
      flags     = '0;
      case (func)
         FUNC_LOOKUP: begin
            if (found) begin
               flags.hit     = 1'b1;
               flags.meta_we = 1'b1;
               hit_id        = ids[match_way];
               order_new     = front_order;
            end else begin
               flags.miss = 1'b1;
            end
         end
         FUNC_INSERT: begin
            flags.meta_we = 1'b1;
            order_new     = front_order;
            if (found) begin
               flags.hit = 1'b1;
            end else begin
               flags.data_we      = 1'b1;
               keys_new[ins_slot] = key;
               ids_new[ins_slot]  = uid;
               if (full) begin
                  flags.evicted = 1'b1;
               end else begin
                  flags.grow = 1'b1;
                  fill_new   = fill + FILL_W'(1);
               end
            end
         end
         FUNC_REMOVE: begin
            if (found) begin
               flags.hit     = 1'b1;
               flags.shrink  = 1'b1;
               flags.meta_we = 1'b1;
               order_new     = drop_order;
               fill_new      = fill - FILL_W'(1);
            end else begin
               flags.miss = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- sv/hashed_lru_key_cache_unit.sv -----
`timescale 1ns / 1ps

// Bucketed key-to-id cache with most-recently-used order in each bucket.
// A request is taken when start is high and busy is low; its result appears
// on rsp_item, marked by rsp_strobe for exactly one cycle, after the row
// read registers of the memories and the response register, and must be
// taken then since the receiver cannot stall. busy is high in the update
// state that follows each transfer, so no new request is taken before the
// last one is through: first the bucket's row is read from the memories,
// then the ways are checked, the recency list is updated and the row is
// written back. After reset a clearing pass puts every bucket's fill count
// to zero and its order to identity; busy stays high throughout it.
module hashed_lru_key_cache_unit import hlkc_pkg::*; #(
   parameter int BUCKETS  = BUCKETS_DEF,
   parameter int WAYS     = WAYS_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int ID_BITS  = ID_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W  = $clog2(WAYS + 1);
   localparam int ORD_W   = WAYS * WAY_W;
   localparam int META_W  = FILL_W + ORD_W;
   localparam int CNT_W   = $clog2(BUCKETS * WAYS + 1);
   localparam int WRAP_N  = 2 ** BUCKET_W;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_WORK  = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [BKT_W-1:0]           clear_cnt_ff, clear_cnt_in;
   func_type                   func_ff;
   logic [BKT_W-1:0]           bkt_ff;
   logic [KEY_BITS-1:0]        key_ff;
   logic [ID_BITS-1:0]         uid_ff;
   logic [CNT_W-1:0]           total_ff, total_in;
   logic                       rsp_strobe_ff;
   rsp_type                    rsp_ff, rsp_in;

   logic                       accept;
   logic [BKT_W-1:0]           wrap_tab [WRAP_N];
   logic [BKT_W-1:0]           req_bkt;

   logic [META_W-1:0]          meta_rd, meta_wr, meta_rst;
   logic                       meta_we;
   logic [BKT_W-1:0]           meta_waddr;
   logic [WAYS-1:0][WAY_W-1:0] order_rst;

   logic [FILL_W-1:0]             fill_rd, fill_new;
   logic [WAYS-1:0][WAY_W-1:0]    order_rd, order_new;
   logic [WAYS-1:0][KEY_BITS-1:0] keys_rd, keys_new;
   logic [WAYS-1:0][ID_BITS-1:0]  ids_rd, ids_new;
   logic [ID_BITS-1:0]            hit_id;
   upd_flags_type                 flags;
   logic                          data_we;

   // request transfer
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // bucket index wrapped modulo the bucket count
   for (genvar g = 0; g < WRAP_N; g++) begin : g_wrap
      assign wrap_tab[g] = BKT_W'(g % BUCKETS);
   end
   assign req_bkt = wrap_tab[req_item.bucket];

   // reset row: empty bucket, identity order
   for (genvar g = 0; g < WAYS; g++) begin : g_ident
      assign order_rst[g] = WAY_W'(g);
   end
   assign meta_rst = {FILL_W'(0), order_rst};

   // control sequencer
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + BKT_W'(1);
            if (clear_cnt_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // request registers, held through the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_item.func;
         bkt_ff  <= req_bkt;
         key_ff  <= KEY_BITS'(req_item.key_tag);
         uid_ff  <= ID_BITS'(req_item.uid_in);
      end
   end

   // bucket metadata: fill count and recency order
   assign fill_rd  = meta_rd[META_W-1 -: FILL_W];
   assign order_rd = meta_rd[ORD_W-1:0];

   assign meta_we    = (state_ff == ST_CLEAR) ||
                       ((state_ff == ST_WORK) && flags.meta_we);
   assign meta_waddr = (state_ff == ST_CLEAR) ? clear_cnt_ff : bkt_ff;
   assign meta_wr    = (state_ff == ST_CLEAR) ? meta_rst : {fill_new, order_new};
   assign data_we    = (state_ff == ST_WORK) && flags.data_we;

   hlkc_ram #(
      .WIDTH (META_W),
      .DEPTH (BUCKETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wr),
      .rd_en   (accept),
      .rd_addr (req_bkt),
      .rd_data (meta_rd)
   );

   // one row of keys per bucket
   hlkc_ram #(
      .WIDTH (WAYS * KEY_BITS),
      .DEPTH (BUCKETS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (bkt_ff),
      .wr_data (keys_new),
      .rd_en   (accept),
      .rd_addr (req_bkt),
      .rd_data (keys_rd)
   );

   // one row of ids per bucket
   hlkc_ram #(
      .WIDTH (WAYS * ID_BITS),
      .DEPTH (BUCKETS)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (bkt_ff),
      .wr_data (ids_new),
      .rd_en   (accept),
      .rd_addr (req_bkt),
      .rd_data (ids_rd)
   );

   // compare ways and build the updated row
   hlkc_bucket_logic #(
      .WAYS     (WAYS),
      .KEY_BITS (KEY_BITS),
      .ID_BITS  (ID_BITS)
   ) u_bucket_logic (
      .func      (func_ff),
      .key       (key_ff),
      .uid       (uid_ff),
      .fill      (fill_rd),
      .order     (order_rd),
      .keys      (keys_rd),
      .ids       (ids_rd),
      .fill_new  (fill_new),
      .order_new (order_new),
      .keys_new  (keys_new),
      .ids_new   (ids_new),
      .hit_id    (hit_id),
      .flags     (flags)
   );

   // running entry count and response word
   always_comb begin
      total_in = total_ff;
      if (flags.grow) begin
         total_in = total_ff + CNT_W'(1);
      end else if (flags.shrink) begin
         total_in = total_ff - CNT_W'(1);
      end
      rsp_in.hit           = flags.hit;
      rsp_in.uid_out       = UID_W'(hit_id);
      rsp_in.status        = flags.miss;
      rsp_in.evicted       = flags.evicted;
      rsp_in.total_entries = TOTAL_W'(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_WORK);
         if (state_ff == ST_WORK) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WORK) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- sv/hlkc_checker.sv -----
`timescale 1ns / 1ps
`include "hashed_lru_key_cache_unit_defines.svh"

module hlkc_checker import hlkc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // a transfer closes the door for the update cycle
   `HLKC_CHECK(a_busy_after_transfer, start && !busy |=> busy, "no busy after transfer")

   // every transfer is followed by a result strobe
   `HLKC_CHECK(a_result_latency, start && !busy |-> ##2 rsp_strobe, "result strobe missing")

   // results never come in adjacent cycles
   `HLKC_CHECK(a_strobe_single, rsp_strobe |=> !rsp_strobe, "strobe longer than one cycle")

   // an eviction is only reported with hit and status low, as on an insert miss
   `HLKC_CHECK(a_evict_is_miss,
               rsp_strobe && rsp_item.evicted |-> !rsp_item.hit && !rsp_item.status,
               "eviction on a hit or failed request")

endmodule

bind hashed_lru_key_cache_unit hlkc_checker u_hlkc_checker (.*);
